// ----- src/mrr_pkg.sv -----
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared codes, limits and types of the Modbus read response receiver.
// ----------------------------------------------------------------------------
package mrr_pkg;

	// Event codes carried by the func field of an input beat.
	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_BYTE    = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_IGNORED  = 3'd0;
	localparam logic [2:0] ST_STORED   = 3'd1;
	localparam logic [2:0] ST_COMPLETE = 3'd2;
	localparam logic [2:0] ST_TIMEOUT  = 3'd3;
	localparam logic [2:0] ST_BUDGET   = 3'd4;

	// Configuration register indexes, taken from address bit 2.
	localparam logic REG_SLAVE_ADDRESS     = 1'b0;
	localparam logic REG_EXPECTED_FUNCTION = 1'b1;

	localparam logic [7:0] SLAVE_ADDRESS_RESET     = 8'd1;
	localparam logic [7:0] EXPECTED_FUNCTION_RESET = 8'd3;

	// Received bytes allowed since a start before the reception is abandoned.
	localparam logic [8:0] BYTE_BUDGET = 9'd500;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] data_byte;
		logic [8:0] byte_index;
		logic [8:0] frame_length;
	} result_t;

endpackage

// ----- src/mrr_parser.sv -----
// ----------------------------------------------------------------------------
// mrr_parser
// Frame parsing state and the per-byte result of the response receiver.
// ----------------------------------------------------------------------------
module mrr_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         func,
	input  logic [7:0]         rx_byte,
	input  logic [7:0]         slave_address,
	input  logic [7:0]         expected_function,
	output mrr_pkg::result_t   result
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HUNT,
		PH_FUNC,
		PH_COUNT,
		PH_BODY,
		PH_CRC
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] byte_count_q, byte_count_n;
	logic [8:0] data_index_q, data_index_n;
	logic [8:0] frame_count_q, frame_count_n;
	logic [8:0] bytes_read_q, bytes_read_n;
	logic       stored;
	logic       complete;

	always_comb begin
		phase_n       = phase_q;
		byte_count_n  = byte_count_q;
		data_index_n  = data_index_q;
		frame_count_n = frame_count_q;
		bytes_read_n  = bytes_read_q;
		stored        = 1'b0;
		complete      = 1'b0;
		result        = '0;
		result.status = mrr_pkg::ST_IGNORED;

		unique case (func)
			mrr_pkg::FUNC_START: begin
				phase_n       = PH_HUNT;
				byte_count_n  = '0;
				data_index_n  = '0;
				frame_count_n = '0;
				bytes_read_n  = '0;
			end
			mrr_pkg::FUNC_TIMEOUT: begin
				if (phase_q != PH_IDLE) begin
					result.status = mrr_pkg::ST_TIMEOUT;
					phase_n       = PH_IDLE;
				end
			end
			mrr_pkg::FUNC_BYTE: begin
				if (phase_q != PH_IDLE) begin
					bytes_read_n = bytes_read_q + 9'd1;
					unique case (phase_q)
						PH_HUNT: begin
							if (rx_byte == slave_address) begin
								stored  = 1'b1;
								phase_n = PH_FUNC;
							end
						end
						PH_FUNC: begin
							if (rx_byte == expected_function) begin
								stored  = 1'b1;
								phase_n = PH_COUNT;
							end else begin
								// Drop the partial frame; this byte is not an address candidate.
								frame_count_n = '0;
								phase_n       = PH_HUNT;
							end
						end
						PH_COUNT: begin
							stored       = 1'b1;
							byte_count_n = rx_byte;
							data_index_n = '0;
							phase_n      = PH_BODY;
						end
						PH_BODY: begin
							stored       = 1'b1;
							data_index_n = data_index_q + 9'd1;
							if (data_index_n > {1'b0, byte_count_q}) begin
								phase_n = PH_CRC;
							end
						end
						PH_CRC: begin
							stored   = 1'b1;
							complete = 1'b1;
							phase_n  = PH_IDLE;
						end
						default: begin
							phase_n = PH_IDLE;
						end
					endcase

					if (stored) begin
						result.data_byte  = rx_byte;
						result.byte_index = frame_count_q;
						frame_count_n     = frame_count_q + 9'd1;
						if (complete) begin
							result.status       = mrr_pkg::ST_COMPLETE;
							result.frame_length = frame_count_n;
						end else begin
							result.status = mrr_pkg::ST_STORED;
						end
					end

					// Completion on the last CRC byte takes precedence over the budget.
					if (!complete && bytes_read_n >= mrr_pkg::BYTE_BUDGET) begin
						result        = '0;
						result.status = mrr_pkg::ST_BUDGET;
						phase_n       = PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			byte_count_q  <= '0;
			data_index_q  <= '0;
			frame_count_q <= '0;
			bytes_read_q  <= '0;
		end else if (accept) begin
			phase_q       <= phase_n;
			byte_count_q  <= byte_count_n;
			data_index_q  <= data_index_n;
			frame_count_q <= frame_count_n;
			bytes_read_q  <= bytes_read_n;
		end
	end

endmodule

// ----- src/modbus_read_response_receiver.sv -----
// ----------------------------------------------------------------------------
// modbus_read_response_receiver
// Modbus RTU read response receiver with an APB-style register port.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_ready  func, rx_byte
// output    out        out_valid/out_ready status, data_byte, byte_index,
//                                          frame_length
// config    in         psel/penable/...   paddr, pwdata, prdata
//
// Every input beat produces exactly one output beat, in the cycle after it is
// accepted. The parser state and the result are computed in the accept cycle
// by a single pass of compare and increment logic; the result lands in the
// output register. A new beat is taken every cycle while the output register
// is empty or being drained, so a stalled consumer stalls the input only when
// the output register still holds an untaken beat.
// Reset clears the parser to idle and loads the register reset values.
//
// A start beat arms the receiver, which then hunts for the slave address. The
// byte after the address must be the expected function code, otherwise the
// partial frame is dropped and hunting resumes. The byte count, count plus one
// body bytes and the final CRC byte follow; each stored byte is reported with
// its position. The last byte reports the frame complete with its length. A
// timeout beat, or exhausting the byte budget since the start, reports an
// error and returns to idle. The CRC is not checked.
// ----------------------------------------------------------------------------
module modbus_read_response_receiver (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  data_byte,
	output logic [8:0]  byte_index,
	output logic [8:0]  frame_length,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic              in_accept;
	logic              cfg_write;
	logic              reg_sel;
	logic [7:0]        slave_address_q;
	logic [7:0]        expected_function_q;
	mrr_pkg::result_t  result;
	mrr_pkg::result_t  result_q;
	logic              out_valid_q;

	// The output register may be refilled in the same cycle it is drained.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	// Register port: registers sit on 4-byte boundaries, so bit 2 selects one.
	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_sel)
			mrr_pkg::REG_SLAVE_ADDRESS:     prdata = {24'd0, slave_address_q};
			mrr_pkg::REG_EXPECTED_FUNCTION: prdata = {24'd0, expected_function_q};
			default:                        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q     <= mrr_pkg::SLAVE_ADDRESS_RESET;
			expected_function_q <= mrr_pkg::EXPECTED_FUNCTION_RESET;
		end else if (cfg_write) begin
			if (reg_sel == mrr_pkg::REG_SLAVE_ADDRESS) begin
				slave_address_q <= pwdata[7:0];
			end else begin
				expected_function_q <= pwdata[7:0];
			end
		end
	end

	mrr_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (in_accept),
		.func              (func),
		.rx_byte           (rx_byte),
		.slave_address     (slave_address_q),
		.expected_function (expected_function_q),
		.result            (result)
	);

	// Output register: holds a beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = result_q.status;
	assign data_byte    = result_q.data_byte;
	assign byte_index   = result_q.byte_index;
	assign frame_length = result_q.frame_length;

endmodule

// ----- src/mrr_checker.sv -----
// ----------------------------------------------------------------------------
// mrr_checker
// Port-level checks of the response receiver, bound to the top level.
// ----------------------------------------------------------------------------
module mrr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [7:0] data_byte,
	input logic [8:0] byte_index,
	input logic [8:0] frame_length
);

	// A beat waiting on the output holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(data_byte) && $stable(byte_index) && $stable(frame_length))
		else $error("output beat changed while stalled");

	// Every accepted input beat yields an output beat in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted beat produced no result");

	// The input is never stalled unless the output holds an untaken beat.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with room in the output register");

	// A frame length appears only with completion, one past the last index.
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == mrr_pkg::ST_COMPLETE)
			? (frame_length == byte_index + 9'd1) : (frame_length == 9'd0))
		else $error("frame length inconsistent with status");

	// Error and ignored beats carry no byte or position.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mrr_pkg::ST_IGNORED || status == mrr_pkg::ST_TIMEOUT
			|| status == mrr_pkg::ST_BUDGET) |-> data_byte == 8'd0 && byte_index == 9'd0)
		else $error("non-data beat carries payload");

endmodule

bind modbus_read_response_receiver mrr_checker u_mrr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.data_byte    (data_byte),
	.byte_index   (byte_index),
	.frame_length (frame_length)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus RTU read response receiver. A driver
// feeds input beats from a queue and a monitor drains result beats. Both
// sides insert random idle cycles. A frame decoder running next to the design
// predicts one result per accepted beat, and the monitor compares every field
// of every result, in order, with that prediction. Register writes happen only
// while the design is idle, and each write is read back over the same port.
// ----------------------------------------------------------------------------
module testbench;
	import mrr_pkg::*;

	// The func field has one unused encoding. The design must ignore it.
	localparam logic [1:0] FUNC_RESERVED = 2'd3;

	// The largest byte count field, giving the longest frame of 260 bytes.
	localparam int MAX_COUNT = 255;

	// Random input beats added in each register setting.
	localparam int RANDOM_PER_SETTING = 70;

	// Length in cycles of the long receiver stall that backs up the input.
	localparam int LONG_HOLD = 200;

	// Hard stop in ns. The slowest correct run is well under a quarter of this.
	localparam int RUN_LIMIT_NS = 3_000_000;

	typedef enum logic [2:0] {
		RX_IDLE,
		RX_HUNT,
		RX_FUNC,
		RX_COUNT,
		RX_BODY,
		RX_CRC
	} rx_phase_e;

	// One queued input beat and the idle cycles the sender waits after it.
	typedef struct {
		logic [1:0] func;
		logic [7:0] rx_byte;
		int         gap;
	} rx_beat_t;

	// Clock, reset and design ports. Every input starts at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = FUNC_START;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  data_byte;
	logic [8:0]  byte_index;
	logic [8:0]  frame_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Register copies and parser state of the frame decoder.
	logic [7:0] cfg_slave;
	logic [7:0] cfg_func;
	rx_phase_e  rx_phase;
	logic [7:0] body_len;
	logic [8:0] body_pos;
	logic [8:0] frame_pos;
	logic [8:0] since_start;

	// Beats waiting to be sent, and the results predicted for sent beats.
	rx_beat_t rx_stream[$];
	result_t  predicted_reports[$];

	rx_beat_t next_beat;
	result_t  want;
	int       send_gap = 0;
	int       take_gap = 0;
	int       pause;
	int       results_seen = 0;
	int       stimulus_count = 0;
	int       mismatches = 0;
	logic     calm = 1'b0;

	modbus_read_response_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("testbench: FAIL");
		$finish;
	end

	// Every failure goes through here: one line each, and all are counted.
	task automatic flag_mismatch(string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Frame decoder. It consumes one input beat, advances the parser and
	// returns the result that the design must produce for that beat.
	function automatic result_t decode_beat(logic [1:0] f, logic [7:0] b);
		result_t r;
		logic    kept;
		r = '0;
		kept = 1'b0;
		if (f == FUNC_START) begin
			// A start always rearms the parser, even in the middle of a frame.
			rx_phase = RX_HUNT;
			body_len = '0;
			body_pos = '0;
			frame_pos = '0;
			since_start = '0;
		end else if (f == FUNC_TIMEOUT) begin
			if (rx_phase != RX_IDLE) begin
				r.status = ST_TIMEOUT;
				rx_phase = RX_IDLE;
			end
		end else if (f == FUNC_BYTE && rx_phase != RX_IDLE) begin
			// Every byte after a start counts toward the budget, stored or not.
			since_start = since_start + 9'd1;
			case (rx_phase)
				RX_HUNT: begin
					if (b == cfg_slave) begin
						kept = 1'b1;
						rx_phase = RX_FUNC;
					end
				end
				RX_FUNC: begin
					// A wrong function code drops the partial frame. The
					// offending byte is not taken as a new address.
					if (b == cfg_func) begin
						kept = 1'b1;
						rx_phase = RX_COUNT;
					end else begin
						frame_pos = '0;
						rx_phase = RX_HUNT;
					end
				end
				RX_COUNT: begin
					kept = 1'b1;
					body_len = b;
					body_pos = '0;
					rx_phase = RX_BODY;
				end
				RX_BODY: begin
					// The body phase also swallows the first CRC byte, so it
					// lasts for the count plus one bytes.
					kept = 1'b1;
					body_pos = body_pos + 9'd1;
					if (body_pos > {1'b0, body_len}) begin
						rx_phase = RX_CRC;
					end
				end
				default: begin
					kept = 1'b1;
					rx_phase = RX_IDLE;
					r.status = ST_COMPLETE;
				end
			endcase
			if (kept) begin
				r.data_byte = b;
				r.byte_index = frame_pos;
				frame_pos = frame_pos + 9'd1;
				if (r.status == ST_COMPLETE) begin
					r.frame_length = frame_pos;
				end else begin
					r.status = ST_STORED;
				end
			end
			// A frame that completes on the very last budgeted byte still
			// counts as complete.
			if (r.status != ST_COMPLETE && since_start >= BYTE_BUDGET) begin
				r = '0;
				r.status = ST_BUDGET;
				rx_phase = RX_IDLE;
			end
		end
		return r;
	endfunction

	task automatic push_beat(logic [1:0] f, logic [7:0] b);
		rx_beat_t beat;
		beat.func = f;
		beat.rx_byte = b;
		beat.gap = calm ? 0 : $urandom_range(0, 19);
		rx_stream.push_back(beat);
		stimulus_count++;
	endtask

	// Bytes that can never be mistaken for the slave address while hunting.
	task automatic push_noise(int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom);
			if (b == cfg_slave) begin
				b = b + 8'd1;
			end
			push_beat(FUNC_BYTE, b);
		end
	endtask

	// Sends the first keep bytes of a well-formed frame with the given byte
	// count. A full frame has count plus five bytes.
	task automatic push_frame(int count, int keep);
		for (int i = 0; i < keep; i++) begin
			if (i == 0) begin
				push_beat(FUNC_BYTE, cfg_slave);
			end else if (i == 1) begin
				push_beat(FUNC_BYTE, cfg_func);
			end else if (i == 2) begin
				push_beat(FUNC_BYTE, 8'(count));
			end else begin
				push_beat(FUNC_BYTE, 8'($urandom));
			end
		end
	endtask

	// Mostly short frames, a few medium ones and now and then the longest.
	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 59);
		if (r == 0) begin
			return MAX_COUNT;
		end
		if (r < 4) begin
			return $urandom_range(13, 80);
		end
		return $urandom_range(0, 12);
	endfunction

	// Waits until every queued beat has gone in and every result has come out.
	task automatic wait_drained();
		while (rx_stream.size() != 0 || in_valid || predicted_reports.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Register read over the APB-style port. The data is taken at the falling
	// edge of the access cycle, well away from the rising edge.
	task automatic check_reg(logic idx, logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== 32'(value)) begin
			flag_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata,
				32'(value)));
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(logic idx, logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SLAVE_ADDRESS) begin
			cfg_slave = value;
		end else begin
			cfg_func = value;
		end
		check_reg(idx, value);
	endtask

	// Driver. At each edge it first records the beat that the design took,
	// then puts the next beat up once the current one is gone and the idle
	// cycles drawn for it have passed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_START;
			rx_byte <= 8'h00;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_reports.push_back(decode_beat(func, rx_byte));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (rx_stream.size() != 0) begin
					next_beat = rx_stream.pop_front();
					in_valid <= 1'b1;
					func <= next_beat.func;
					rx_byte <= next_beat.rx_byte;
					send_gap <= next_beat.gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. It checks each result beat against the oldest prediction, then
	// drops ready for a number of cycles drawn per beat. Every few hundred
	// beats there is a run with no stall at all, and a few times in the run a
	// long stall lets the input back up behind the full output register.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_gap <= 0;
		end else begin
			pause = take_gap;
			if (out_valid && out_ready) begin
				if (predicted_reports.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with nothing pending, status %0d",
						results_seen, status));
				end else begin
					want = predicted_reports.pop_front();
					if (status !== want.status) begin
						flag_mismatch($sformatf("result %0d status %0d, expected %0d",
							results_seen, status, want.status));
					end
					if (data_byte !== want.data_byte) begin
						flag_mismatch($sformatf("result %0d data_byte %h, expected %h",
							results_seen, data_byte, want.data_byte));
					end
					if (byte_index !== want.byte_index) begin
						flag_mismatch($sformatf("result %0d byte_index %0d, expected %0d",
							results_seen, byte_index, want.byte_index));
					end
					if (frame_length !== want.frame_length) begin
						flag_mismatch($sformatf("result %0d frame_length %0d, expected %0d",
							results_seen, frame_length, want.frame_length));
					end
				end
				results_seen++;
				if (results_seen % 500 == 300) begin
					pause = LONG_HOLD;
				end else if ((results_seen / 150) % 4 == 3) begin
					pause = 0;
				end else begin
					pause = $urandom_range(0, 19);
				end
			end
			if (pause > 0) begin
				out_ready <= 1'b0;
				take_gap <= pause - 1;
			end else begin
				out_ready <= 1'b1;
				take_gap <= 0;
			end
		end
	end

	// Stimulus. Five register settings: the reset values, both registers at
	// zero, both at all ones, and two random pairs. The first three settings get a
	// directed part, and every setting gets random frame traffic.
	initial begin
		int         kind;
		int         n;
		int         target;
		logic [7:0] new_slave;
		logic [7:0] new_func;

		cfg_slave = SLAVE_ADDRESS_RESET;
		cfg_func = EXPECTED_FUNCTION_RESET;
		rx_phase = RX_IDLE;
		body_len = '0;
		body_pos = '0;
		frame_pos = '0;
		since_start = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reg(REG_SLAVE_ADDRESS, SLAVE_ADDRESS_RESET);
		check_reg(REG_EXPECTED_FUNCTION, EXPECTED_FUNCTION_RESET);

		for (int setting = 0; setting < 5; setting++) begin
			if (setting > 0) begin
				wait_drained();
				// Every beat yields a result, so nothing is still in flight
				// here. The extra wait is only a safety margin.
				repeat (4) @(posedge clk);
				case (setting)
					1: begin
						new_slave = 8'h00;
						new_func = 8'h00;
					end
					2: begin
						new_slave = 8'hFF;
						new_func = 8'hFF;
					end
					default: begin
						new_slave = 8'($urandom);
						new_func = 8'($urandom);
					end
				endcase
				write_reg(REG_SLAVE_ADDRESS, new_slave);
				write_reg(REG_EXPECTED_FUNCTION, new_func);
			end

			case (setting)
				0: begin
					// Bytes, a timeout and the unused code before any start.
					push_beat(FUNC_BYTE, 8'h01);
					push_beat(FUNC_TIMEOUT, 8'h00);
					push_beat(FUNC_RESERVED, 8'hFF);
					// A non-address byte while hunting, then an address with
					// a wrong function code, then the real frame with a
					// count of zero.
					push_beat(FUNC_START, 8'hFF);
					push_beat(FUNC_BYTE, 8'h00);
					push_beat(FUNC_BYTE, cfg_slave);
					push_beat(FUNC_BYTE, 8'hFF);
					push_beat(FUNC_BYTE, cfg_slave);
					push_beat(FUNC_BYTE, cfg_func);
					push_beat(FUNC_BYTE, 8'h00);
					push_beat(FUNC_BYTE, 8'hFF);
					push_beat(FUNC_BYTE, 8'h00);
					// After a complete frame the parser sits idle.
					push_beat(FUNC_BYTE, cfg_slave);
					// The unused code and a timeout in the middle of a frame.
					push_beat(FUNC_START, 8'h00);
					push_frame(1, 4);
					push_beat(FUNC_RESERVED, 8'h00);
					push_beat(FUNC_TIMEOUT, 8'hFF);
					// A fresh start cuts a frame short, then a timeout while
					// hunting.
					push_beat(FUNC_START, 8'h55);
					push_frame(0, 2);
					push_beat(FUNC_START, 8'hAA);
					push_beat(FUNC_TIMEOUT, 8'h00);
				end
				1: begin
					// The longest frame ends exactly on the last budgeted
					// byte, so the frame completes.
					push_beat(FUNC_START, 8'h00);
					push_noise(500 - (MAX_COUNT + 5));
					push_frame(MAX_COUNT, MAX_COUNT + 5);
				end
				2: begin
					// The budget runs out inside the body of the longest
					// frame. The bytes after that are ignored.
					push_beat(FUNC_START, 8'h00);
					push_noise(505 - (MAX_COUNT + 5));
					push_frame(MAX_COUNT, MAX_COUNT + 5);
				end
				default: begin
				end
			endcase

			// Random part. Most sequences are well-formed frames with random
			// content. The rest are dropped, cut short or restarted frames,
			// and loose beats of any code.
			target = stimulus_count + RANDOM_PER_SETTING;
			while (stimulus_count < target) begin
				kind = $urandom_range(0, 99);
				calm = ($urandom_range(0, 4) == 0);
				if (kind < 55) begin
					push_beat(FUNC_START, 8'($urandom));
					push_noise($urandom_range(0, 3));
					n = pick_count();
					push_frame(n, n + 5);
				end else if (kind < 68) begin
					push_beat(FUNC_START, 8'($urandom));
					push_noise($urandom_range(0, 2));
					push_beat(FUNC_BYTE, cfg_slave);
					push_beat(FUNC_BYTE, cfg_func + 8'($urandom_range(1, 255)));
					n = pick_count();
					push_frame(n, n + 5);
				end else if (kind < 80) begin
					push_beat(FUNC_START, 8'($urandom));
					n = pick_count();
					push_frame(n, $urandom_range(1, n + 4));
					push_beat(FUNC_TIMEOUT, 8'($urandom));
				end else if (kind < 88) begin
					push_beat(FUNC_START, 8'($urandom));
					n = pick_count();
					push_frame(n, $urandom_range(1, n + 4));
					push_beat(FUNC_START, 8'($urandom));
					n = pick_count();
					push_frame(n, n + 5);
				end else begin
					repeat ($urandom_range(1, 6)) begin
						push_beat(2'($urandom_range(0, 3)), 8'($urandom));
					end
				end
				calm = 1'b0;
			end
		end

		wait_drained();
		// One result per beat, each from a single output register. A short wait is
		// enough to catch any stray result.
		repeat (8) @(posedge clk);
		if (mismatches == 0 && predicted_reports.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/mrr_pkg.sv
src/mrr_parser.sv
src/modbus_read_response_receiver.sv
src/mrr_checker.sv
verif/testbench.sv
